// ===== rtl/fspc_pkg.sv =====
// ----------------------------------------------------------------------------
// fspc_pkg
// Types, constants and the control store of the fixed-step pulse clock.
// ----------------------------------------------------------------------------
package fspc_pkg;

	// Configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	typedef enum logic {
		REG_FIXED_STEP  = 1'b0,
		REG_START_SCALE = 1'b1
	} reg_idx_t;

	// Reset values and defaults
	localparam logic [31:0] DEFAULT_STEP    = 32'd279620;
	localparam logic [23:0] START_SCALE_RST = 24'd65536;
	localparam int          MAX_PULSES_DEF  = 8;

	// Transaction payloads
	typedef struct packed {
		logic [31:0] frame_dt;
		logic [31:0] spare_dt;
		logic        new_request;
		logic [23:0] scale_goal;
		logic [23:0] ramp_rate;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  tick_pulses;
		logic [31:0] scaled_dt;
		logic [47:0] elapsed_time;
		logic [23:0] scale_now;
		logic        clamped;
		logic        ramp_done;
	} out_item_t;

	// Sequencer
	typedef logic [2:0] step_t;

	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_WAIT_IN,
		JMP_LOOP_SUB,
		JMP_WAIT_OUT
	} jmp_t;

	typedef struct packed {
		logic  load;
		logic  mul_ramp;
		logic  mul_scale;
		logic  ramp;
		logic  sat;
		logic  accum;
		logic  sub;
		logic  finish;
		jmp_t  jmp;
		step_t tgt;
	} uword_t;

	localparam step_t ST_FETCH     = 3'd0;
	localparam step_t ST_MUL_RAMP  = 3'd1;
	localparam step_t ST_RAMP      = 3'd2;
	localparam step_t ST_MUL_SCALE = 3'd3;
	localparam step_t ST_SAT       = 3'd4;
	localparam step_t ST_ACCUM     = 3'd5;
	localparam step_t ST_PULSE     = 3'd6;
	localparam step_t ST_FINISH    = 3'd7;

	// Control store: one word per step, the last step wraps to the fetch
	function automatic uword_t fspc_ucode(input step_t s);
		uword_t w;
		w = '0;
		w.jmp = JMP_NEXT;
		w.tgt = ST_FETCH;
		case (s)
			ST_FETCH: begin
				w.load = 1'b1;
				w.jmp  = JMP_WAIT_IN;
				w.tgt  = ST_FETCH;
			end
			ST_MUL_RAMP:  w.mul_ramp  = 1'b1;
			ST_RAMP:      w.ramp      = 1'b1;
			ST_MUL_SCALE: w.mul_scale = 1'b1;
			ST_SAT:       w.sat       = 1'b1;
			ST_ACCUM:     w.accum     = 1'b1;
			ST_PULSE: begin
				w.sub = 1'b1;
				w.jmp = JMP_LOOP_SUB;
				w.tgt = ST_PULSE;
			end
			ST_FINISH: begin
				w.finish = 1'b1;
				w.jmp    = JMP_WAIT_OUT;
				w.tgt    = ST_FINISH;
			end
			default: w.jmp = JMP_NEXT;
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/fixed_step_pulse_clock_unit.sv =====
// A new frame is taken only after the last one has passed the finish step; the step
// loop of the sequencer subtracts one fixed step per cycle from the accumulator.
// The next frame is taken while the result still waits in the output register.
// Reset (arst_n low): scale = start_scale, accumulator, total and ramp cleared,
// registers back to their defaults; no clearing pass.
// ----------------------------------------------------------------------------
// fixed_step_pulse_clock_unit
// Fixed-timestep pulse generator with time-scale ramp, run by a small
// microcoded sequencer over one 24x32 multiplier and a 33-bit accumulator.
// ----------------------------------------------------------------------------
module fixed_step_pulse_clock_unit #(
	parameter int MAX_PULSES = fspc_pkg::MAX_PULSES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  fspc_pkg::in_item_t              item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output fspc_pkg::out_item_t             result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fspc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [fspc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [fspc_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);
	import fspc_pkg::*;

	localparam int PCNT_W = $clog2(MAX_PULSES + 1);

	// Configuration
	logic [31:0] fixed_step_q;
	logic [23:0] start_scale_q;
	reg_idx_t    reg_idx;
	logic        cfg_wr;

	// Sequencer
	step_t  step_q;
	uword_t uw;
	logic   hold;
	logic   out_busy;
	logic   sub_go;
	logic   load_go;
	logic   finish_go;

	// Datapath
	logic [31:0]       dt_q;
	logic              pending_q;
	logic [23:0]       target_q;
	logic [23:0]       speed_q;
	logic [23:0]       scale_q;
	logic [55:0]       prod_q;
	logic [31:0]       scaled_q;
	logic [32:0]       acc_q;
	logic [47:0]       total_q;
	logic [PCNT_W-1:0] pulses_q;
	logic              done_q;
	logic              result_valid_q;
	out_item_t         result_q;

	logic [23:0] mul_a;
	logic [55:0] mul_p;
	logic [31:0] step_eff;
	logic [31:0] ramp_delta;
	logic [23:0] ramp_diff;
	logic        clamp_hit;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_comb begin
		case (reg_idx)
			REG_FIXED_STEP:  prdata = fixed_step_q;
			REG_START_SCALE: prdata = {8'd0, start_scale_q};
			default:         prdata = '0;
		endcase
	end

	// Control word and branch conditions
	assign uw        = fspc_ucode(step_q);
	assign out_busy  = result_valid_q & ~result_ready;
	assign step_eff  = (fixed_step_q != 32'd0) ? fixed_step_q : DEFAULT_STEP;
	assign sub_go    = (acc_q >= {1'b0, step_eff}) && (pulses_q < PCNT_W'(MAX_PULSES));
	assign clamp_hit = (pulses_q >= PCNT_W'(MAX_PULSES)) && (acc_q >= {1'b0, step_eff});

	always_comb begin
		case (uw.jmp)
			JMP_WAIT_IN:  hold = ~item_valid;
			JMP_LOOP_SUB: hold = sub_go;
			JMP_WAIT_OUT: hold = out_busy;
			default:      hold = 1'b0;
		endcase
	end

	assign item_ready = uw.load;
	assign load_go    = uw.load & item_valid;
	assign finish_go  = uw.finish & ~out_busy;

	assign mul_a      = uw.mul_ramp ? speed_q : scale_q;
	assign mul_p      = 56'(mul_a) * 56'(dt_q);
	assign ramp_delta = prod_q[55:24];
	assign ramp_diff  = (target_q >= scale_q) ? (target_q - scale_q) : (scale_q - target_q);

	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q         <= ST_FETCH;
			fixed_step_q   <= DEFAULT_STEP;
			start_scale_q  <= START_SCALE_RST;
			scale_q        <= START_SCALE_RST;
			pending_q      <= 1'b0;
			target_q       <= '0;
			speed_q        <= '0;
			acc_q          <= '0;
			total_q        <= '0;
			pulses_q       <= '0;
			done_q         <= 1'b0;
			dt_q           <= '0;
			prod_q         <= '0;
			scaled_q       <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			step_q <= hold ? uw.tgt : step_t'(step_q + 3'd1);

			if (cfg_wr) begin
				case (reg_idx)
					REG_FIXED_STEP: fixed_step_q <= pwdata;
					REG_START_SCALE: begin
						start_scale_q <= pwdata[23:0];
						scale_q       <= pwdata[23:0];
					end
					default: fixed_step_q <= fixed_step_q;
				endcase
			end

			if (load_go) begin
				dt_q   <= (item.frame_dt != 32'd0) ? item.frame_dt : item.spare_dt;
				done_q <= 1'b0;
				if (item.new_request) begin
					pending_q <= 1'b1;
					target_q  <= item.scale_goal;
					speed_q   <= item.ramp_rate;
				end
			end

			if (uw.mul_ramp || uw.mul_scale)
				prod_q <= mul_p;

			// Slew toward the target, snap when within one step
			if (uw.ramp && pending_q) begin
				if ({8'd0, ramp_diff} <= ramp_delta) begin
					scale_q   <= target_q;
					pending_q <= 1'b0;
					done_q    <= 1'b1;
				end else if (target_q > scale_q) begin
					scale_q <= scale_q + ramp_delta[23:0];
				end else begin
					scale_q <= scale_q - ramp_delta[23:0];
				end
			end

			// Drop the fraction, saturate to 32 bits
			if (uw.sat)
				scaled_q <= (|prod_q[55:48]) ? 32'hFFFF_FFFF : prod_q[47:16];

			if (uw.accum) begin
				total_q  <= total_q + 48'(scaled_q);
				acc_q    <= acc_q + 33'(scaled_q);
				pulses_q <= '0;
			end

			if (uw.sub && sub_go) begin
				acc_q    <= acc_q - {1'b0, step_eff};
				pulses_q <= pulses_q + PCNT_W'(1);
			end

			if (finish_go) begin
				if (clamp_hit)
					acc_q <= '0;
				result_q.tick_pulses  <= 4'(pulses_q);
				result_q.scaled_dt    <= scaled_q;
				result_q.elapsed_time <= total_q;
				result_q.scale_now    <= scale_q;
				result_q.clamped      <= clamp_hit;
				result_q.ramp_done    <= done_q;
				result_valid_q        <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/fspc_checker.sv =====
// ----------------------------------------------------------------------------
// fspc_checker
// Port-level checks of the fixed-step pulse clock, bound to the top level.
// ----------------------------------------------------------------------------
module fspc_checker #(
	parameter int MAX_PULSES = fspc_pkg::MAX_PULSES_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_ready,
	input logic                result_valid,
	input logic                result_ready,
	input fspc_pkg::out_item_t result
);
	import fspc_pkg::*;

	// A stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed or dropped while stalled");

	// The sequencer is busy in the cycle after a transaction is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("input taken twice in a row");

	// Clamping only happens at the full pulse count
	a_clamp_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.clamped |-> result.tick_pulses == 4'(MAX_PULSES))
		else $error("clamped without reaching the pulse limit");

	// A fresh result never rises right after an input transaction
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !$past(item_valid && item_ready))
		else $error("result appeared right after an input transaction");

endmodule

bind fixed_step_pulse_clock_unit fspc_checker #(.MAX_PULSES(MAX_PULSES)) u_fspc_checker (.*);

// ===== tb/fixed_step_pulse_clock_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_step_pulse_clock_unit_tb
// Self-checking bench for the fixed-step pulse clock. A directed table of
// frame ticks is followed by random ticks under several register settings.
// Each result is compared field by field against a typed row of the table or a
// cycle-free predictor of the scale ramp, the scaled delta, the running total and the pulse loop.
// ----------------------------------------------------------------------------
module fixed_step_pulse_clock_unit_tb;
	import fspc_pkg::*;

	localparam int PULSE_LIMIT   = MAX_PULSES_DEF;
	localparam int IDLE_PCT      = 12;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = 40;
	localparam int PHASES        = 6;
	localparam int PHASE_FRAMES  = 330;
	localparam int DIR_N         = 23;
	localparam longint TIMEOUT_NS = 5_000_000;

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_ready;
	in_item_t              item;
	logic                  result_valid;
	logic                  result_ready;
	out_item_t             result;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	fixed_step_pulse_clock_unit #(.MAX_PULSES(PULSE_LIMIT)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	// Predicted block state and register copies
	logic [31:0] cfg_step    = DEFAULT_STEP;
	logic [23:0] cur_scale   = START_SCALE_RST;
	logic [32:0] step_acc    = '0;
	logic [47:0] run_total   = '0;
	logic        ramp_armed  = 1'b0;
	logic [23:0] ramp_goal   = '0;
	logic [23:0] ramp_speed  = '0;

	out_item_t frame_results_due[$];

	int  bad_fields     = 0;
	int  frames_checked = 0;
	int  clamp_hits     = 0;
	int  ramps_finished = 0;
	int  settings_used  = 1;
	int  stall_asked    = 0;
	int  stall_served   = 0;
	bit  calm           = 1'b0;

	typedef struct packed {
		in_item_t  stim;
		logic      typed;
		out_item_t want;
	} frame_row_t;

	localparam out_item_t NO_CHECK = '0;

	// Rows with typed results run first, from reset, and each leaves the accumulator empty
	frame_row_t dir_rows [DIR_N] = '{
		{{32'd0, 32'd0, 1'b0, 24'd0, 24'd0}, 1'b1,
			{4'd0, 32'd0, 48'd0, 24'd65536, 1'b0, 1'b0}},
		{{32'd279620, 32'd0, 1'b0, 24'd0, 24'd0}, 1'b1,
			{4'd1, 32'd279620, 48'd279620, 24'd65536, 1'b0, 1'b0}},
		{{32'd0, 32'd559240, 1'b0, 24'd0, 24'd0}, 1'b1,
			{4'd2, 32'd559240, 48'd838860, 24'd65536, 1'b0, 1'b0}},
		{{32'hFFFFFFFF, 32'd0, 1'b0, 24'd0, 24'd0}, 1'b1,
			{4'd8, 32'hFFFFFFFF, 48'd4295806155, 24'd65536, 1'b1, 1'b0}},
		{{32'd0, 32'hFFFFFFFF, 1'b0, 24'd0, 24'd0}, 1'b0, NO_CHECK},
		{{32'd279620, 32'd0, 1'b1, 24'h020000, 24'h010000}, 1'b0, NO_CHECK},
		{{32'h01000000, 32'd0, 1'b0, 24'd0, 24'd0}, 1'b0, NO_CHECK},
		{{32'd279620, 32'd0, 1'b1, 24'h008000, 24'h100000}, 1'b0, NO_CHECK},
		{{32'd279620, 32'd0, 1'b1, 24'h00C000, 24'd0}, 1'b0, NO_CHECK},
		{{32'd0, 32'd0, 1'b0, 24'hFFFFFF, 24'hFFFFFF}, 1'b0, NO_CHECK},
		{{32'd279620, 32'd0, 1'b1, 24'd113596, 24'd0}, 1'b0, NO_CHECK},
		{{32'hFFFFFFFF, 32'd0, 1'b1, 24'hFFFFFF, 24'hFFFFFF}, 1'b0, NO_CHECK},
		{{32'd1, 32'hFFFFFFFF, 1'b0, 24'd0, 24'd0}, 1'b0, NO_CHECK},
		{{32'h01000000, 32'd0, 1'b1, 24'd0, 24'hFFFFFF}, 1'b0, NO_CHECK},
		{{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 24'd0, 24'd0}, 1'b0, NO_CHECK},
		{{32'h01000000, 32'd0, 1'b1, 24'h010000, 24'd1}, 1'b0, NO_CHECK},
		{{32'h00800000, 32'd0, 1'b1, 24'h010000, 24'hFFFFFF}, 1'b0, NO_CHECK},
		{{32'd279619, 32'd0, 1'b0, 24'd0, 24'd0}, 1'b0, NO_CHECK},
		{{32'd1, 32'd0, 1'b0, 24'd0, 24'd0}, 1'b0, NO_CHECK},
		{{32'd2236960, 32'd0, 1'b0, 24'd0, 24'd0}, 1'b0, NO_CHECK},
		{{32'd2516580, 32'd0, 1'b0, 24'd0, 24'd0}, 1'b0, NO_CHECK},
		{{32'h55555555, 32'hAAAAAAAA, 1'b1, 24'hAAAAAA, 24'h555555}, 1'b0, NO_CHECK},
		{{32'h01000000, 32'd0, 1'b1, 24'h010000, 24'hFFFFFF}, 1'b0, NO_CHECK}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("fixed_step_pulse_clock_unit_tb: errors");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
		bad_fields++;
	endtask

	// Advance the predicted clock by one frame tick and return its result
	function automatic out_item_t advance_frame(input in_item_t it);
		out_item_t   o;
		logic [31:0] dt;
		logic [31:0] stp;
		logic [55:0] prod;
		logic [31:0] ramp_delta;
		logic [23:0] gap;
		logic [31:0] sdt;
		logic [32:0] acc;
		int          n;
		logic        clamp;
		logic        done;
		dt    = (it.frame_dt != '0) ? it.frame_dt : it.spare_dt;
		stp   = (cfg_step != '0) ? cfg_step : DEFAULT_STEP;
		clamp = 1'b0;
		done  = 1'b0;
		n     = 0;
		if (it.new_request) begin
			ramp_armed = 1'b1;
			ramp_goal  = it.scale_goal;
			ramp_speed = it.ramp_rate;
		end
		if (ramp_armed) begin
			prod       = {32'd0, ramp_speed} * {24'd0, dt};
			ramp_delta = prod[55:24];
			gap = (ramp_goal >= cur_scale) ? ramp_goal - cur_scale : cur_scale - ramp_goal;
			if ({8'd0, gap} <= ramp_delta) begin
				cur_scale  = ramp_goal;
				ramp_armed = 1'b0;
				done       = 1'b1;
			end else if (ramp_goal > cur_scale) begin
				cur_scale = cur_scale + ramp_delta[23:0];
			end else begin
				cur_scale = cur_scale - ramp_delta[23:0];
			end
		end
		prod = {32'd0, cur_scale} * {24'd0, dt};
		sdt  = (prod[55:48] != '0) ? 32'hFFFFFFFF : prod[47:16];
		run_total = run_total + {16'd0, sdt};
		acc = step_acc + {1'b0, sdt};
		while (acc >= {1'b0, stp} && n < PULSE_LIMIT) begin
			acc = acc - {1'b0, stp};
			n++;
		end
		// excess left after the last allowed pulse is dropped
		if (n >= PULSE_LIMIT && acc >= {1'b0, stp}) begin
			acc   = '0;
			clamp = 1'b1;
		end
		step_acc = acc;
		o.tick_pulses  = 4'(n);
		o.scaled_dt    = sdt;
		o.elapsed_time = run_total;
		o.scale_now    = cur_scale;
		o.clamped      = clamp;
		o.ramp_done    = done;
		return o;
	endfunction

	task automatic offer_frame(input in_item_t it, input logic typed, input out_item_t want);
		out_item_t p;
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		p = advance_frame(it);
		frame_results_due.push_back(typed ? want : p);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		item_valid <= 1'b0;
		while (frame_results_due.size() != 0) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t r, input logic [31:0] d);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= d;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (r == REG_FIXED_STEP) begin
			cfg_step = d;
		end else begin
			cur_scale = d[23:0];
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_register(input reg_idx_t r, input logic [31:0] want);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {r, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want)
			report_mismatch(r == REG_FIXED_STEP ? "fixed_step readback" : "start_scale readback",
				64'(prdata), 64'(want));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Receiver: random backpressure, plus a long hold-off on request
	initial begin
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_asked != stall_served) begin
				result_ready <= 1'b0;
				stall_served++;
				for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clk);
			end
			result_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && result_valid && result_ready) begin
			if (frame_results_due.size() == 0) begin
				report_mismatch("result with no frame outstanding",
					64'(result.scaled_dt), 64'd0);
			end else begin
				e = frame_results_due.pop_front();
				if (result.tick_pulses !== e.tick_pulses)
					report_mismatch("tick_pulses", 64'(result.tick_pulses),
						64'(e.tick_pulses));
				if (result.scaled_dt !== e.scaled_dt)
					report_mismatch("scaled_dt", 64'(result.scaled_dt), 64'(e.scaled_dt));
				if (result.elapsed_time !== e.elapsed_time)
					report_mismatch("elapsed_time", 64'(result.elapsed_time),
						64'(e.elapsed_time));
				if (result.scale_now !== e.scale_now)
					report_mismatch("scale_now", 64'(result.scale_now), 64'(e.scale_now));
				if (result.clamped !== e.clamped)
					report_mismatch("clamped", 64'(result.clamped), 64'(e.clamped));
				if (result.ramp_done !== e.ramp_done)
					report_mismatch("ramp_done", 64'(result.ramp_done), 64'(e.ramp_done));
				frames_checked++;
				clamp_hits     += int'(e.clamped);
				ramps_finished += int'(e.ramp_done);
			end
		end
	end

	initial begin
		in_item_t    fr;
		logic [31:0] new_step;
		logic [23:0] new_scale;
		int          sel;
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		check_register(REG_FIXED_STEP, DEFAULT_STEP);
		check_register(REG_START_SCALE, {8'd0, START_SCALE_RST});

		for (int i = 0; i < DIR_N; i++)
			offer_frame(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

		for (int ph = 1; ph <= PHASES; ph++) begin
			wait_drained();
			calm = 1'b0;
			case (ph)
				1: begin
					new_step  = DEFAULT_STEP;
					new_scale = START_SCALE_RST;
				end
				2: begin
					new_step  = 32'd1;
					new_scale = 24'hFFFFFF;
				end
				3: begin
					// zero step falls back to the default period
					new_step  = 32'd0;
					new_scale = 24'd0;
				end
				4: begin
					new_step  = 32'hFFFFFFFF;
					new_scale = 24'h008000;
				end
				default: begin
					new_step  = $urandom_range(DEFAULT_STEP / 4, DEFAULT_STEP * 4);
					new_scale = 24'($urandom_range(0, 24'h40000));
				end
			endcase
			apb_write(REG_FIXED_STEP, new_step);
			apb_write(REG_START_SCALE, {8'd0, new_scale});
			check_register(REG_FIXED_STEP, new_step);
			check_register(REG_START_SCALE, {8'd0, new_scale});
			settings_used++;
			calm = (ph == 1);

			for (int k = 0; k < PHASE_FRAMES; k++) begin
				if (ph == 2 && k == 100)
					stall_asked++;
				if (ph == 5 && k == 150)
					wait_drained();
				sel = $urandom_range(0, 99);
				if (sel < 55)
					fr.frame_dt = $urandom_range(1, 600000);
				else if (sel < 70)
					fr.frame_dt = '0;
				else if (sel < 85)
					fr.frame_dt = $urandom;
				else
					fr.frame_dt = $urandom_range(0, 16);
				fr.spare_dt = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 600000);
				fr.new_request = ($urandom_range(0, 99) < 15);
				fr.scale_goal = ($urandom_range(0, 9) < 7) ?
					24'($urandom_range(0, 24'h40000)) : 24'($urandom);
				sel = $urandom_range(0, 9);
				if (sel < 4)
					fr.ramp_rate = 24'($urandom_range(0, 24'h80000));
				else if (sel < 7)
					fr.ramp_rate = 24'($urandom);
				else
					fr.ramp_rate = 24'($urandom_range(0, 24'h2000));
				offer_frame(fr, 1'b0, NO_CHECK);
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d frame ticks checked under %0d register settings",
			frames_checked, settings_used);
		$display("summary: %0d ticks hit the pulse limit, %0d scale ramps reached target",
			clamp_hits, ramps_finished);
		if (bad_fields == 0 && frame_results_due.size() == 0) begin
			$display("fixed_step_pulse_clock_unit_tb: clean");
		end else begin
			$display("fixed_step_pulse_clock_unit_tb: errors");
		end
		$finish;
	end

endmodule

// ===== fixed_step_pulse_clock_unit.f =====
rtl/fspc_pkg.sv
rtl/fixed_step_pulse_clock_unit.sv
rtl/fspc_checker.sv
tb/fixed_step_pulse_clock_unit_tb.sv
